// ----- design/gcd_pkg.sv -----
// shared constants, widths and the cordic arctangent table for the great-circle distance block
// no dependencies; every design file refers to it by scoped names
package gcd_pkg;

	// datapath widths
	localparam int CW     = 34;   // cordic x, y, z width (signed)
	localparam int SQ_NW  = 62;   // square root radicand width
	localparam int SQ_RW  = 36;   // square root partial remainder width
	localparam int SQ_QW  = 31;   // square root result width
	localparam int SQ_CELLS = SQ_NW / 2;

	// degree to binary angle divisors (full angle and half angle)
	localparam int DIV_FULL = 360;
	localparam int DIV_HALF = 720;

	// both divisors are 45 times a power of two: the power of two is a shift,
	// the 45 is done by reciprocal multiplication, 16 dividend bits per cell
	localparam int DIV_ODD   = 45;
	localparam int FULL_SH   = 3;    // 360 = 45 << 3
	localparam int HALF_SH   = 4;    // 720 = 45 << 4
	localparam int DIV_BIAS  = (DIV_FULL / 2) >> FULL_SH;   // same for the half angle
	localparam int DIV_W     = 48;   // dividend width after the shift
	localparam int DIV_DIG   = 16;   // dividend bits per cell
	localparam int DIV_CELLS = DIV_W / DIV_DIG;
	localparam int REM_W     = 6;    // remainder width, below 45
	localparam int RECIP_W   = 26;
	localparam int DIV_RSH   = 31;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd47721859;   // ceil(2^31 / 45)

	localparam logic [31:0] RADIUS_RESET = 32'd225448100;
	localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;
	localparam logic [32:0] PI_Q31       = 33'd6746518852;
	localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

	// atan(2^-k) as a binary angle, 2^32 per turn
	function automatic logic [31:0] atan_val(input int k);
		logic [31:0] v;
		case (k)
			0:  v = 32'h2000_0000;
			1:  v = 32'h12E4_051D;
			2:  v = 32'h09FB_385B;
			3:  v = 32'h0511_11D4;
			4:  v = 32'h028B_0D43;
			5:  v = 32'h0145_D7E1;
			6:  v = 32'h00A2_F61E;
			7:  v = 32'h0051_7C55;
			8:  v = 32'h0028_BE53;
			9:  v = 32'h0014_5F2E;
			10: v = 32'h000A_2F98;
			11: v = 32'h0005_17CC;
			12: v = 32'h0002_8BE6;
			13: v = 32'h0001_45F3;
			14: v = 32'h0000_A2F9;
			15: v = 32'h0000_517C;
			16: v = 32'h0000_28BE;
			17: v = 32'h0000_145F;
			18: v = 32'h0000_0A2F;
			19: v = 32'h0000_0517;
			20: v = 32'h0000_028B;
			21: v = 32'h0000_0145;
			22: v = 32'h0000_00A2;
			23: v = 32'h0000_0051;
			24: v = 32'h0000_0028;
			25: v = 32'h0000_0014;
			26: v = 32'h0000_000A;
			27: v = 32'h0000_0005;
			28: v = 32'h0000_0002;
			29: v = 32'h0000_0001;
			default: v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage

// ----- design/gcd_div_cell.sv -----
// one step of a divide-by-45 chain by reciprocal multiplication, 16 quotient bits per cell
// depends on gcd_pkg
module gcd_div_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [gcd_pkg::DIV_W-1:0]   n_in,
	input  logic [gcd_pkg::REM_W-1:0]   rem_in,
	input  logic [31:0]                 q_in,
	input  logic                        neg_in,
	output logic [gcd_pkg::DIV_W-1:0]   n_q,
	output logic [gcd_pkg::REM_W-1:0]   rem_q,
	output logic [31:0]                 q_q,
	output logic                        neg_q
);

	localparam int DG = gcd_pkg::DIV_DIG;
	localparam int XW = gcd_pkg::REM_W + DG;
	localparam int PW = XW + gcd_pkg::RECIP_W;

	logic [XW-1:0] x;
	logic [PW-1:0] prod;
	logic [DG-1:0] qd;
	logic [XW-1:0] r;

	// x stays below 45 * 2^16, so the reciprocal gives the exact floor
	always_comb begin
		x    = {rem_in, n_in[gcd_pkg::DIV_W-1 -: DG]};
		prod = PW'(x) * PW'(gcd_pkg::DIV_RECIP);
		qd   = prod[gcd_pkg::DIV_RSH +: DG];
		r    = x - XW'(qd) * XW'(gcd_pkg::DIV_ODD);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_q   <= {n_in[gcd_pkg::DIV_W-DG-1:0], {DG{1'b0}}};
			rem_q <= r[gcd_pkg::REM_W-1:0];
			q_q   <= {q_in[31-DG:0], qd};
			neg_q <= neg_in;
		end
	end

endmodule

// ----- design/gcd_rot_cell.sv -----
// one rotation-mode cordic micro-rotation (sine and cosine)
// depends on gcd_pkg
module gcd_rot_cell #(
	parameter int K = 0
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [gcd_pkg::CW-1:0]  x_in,
	input  logic signed [gcd_pkg::CW-1:0]  y_in,
	input  logic signed [gcd_pkg::CW-1:0]  z_in,
	input  logic                           neg_in,
	output logic signed [gcd_pkg::CW-1:0]  x_q,
	output logic signed [gcd_pkg::CW-1:0]  y_q,
	output logic signed [gcd_pkg::CW-1:0]  z_q,
	output logic                           neg_q
);

	localparam logic signed [gcd_pkg::CW-1:0] ATAN =
		$signed({2'b00, gcd_pkg::atan_val(K)});

	logic signed [gcd_pkg::CW-1:0] dx;
	logic signed [gcd_pkg::CW-1:0] dy;

	assign dx = y_in >>> K;
	assign dy = x_in >>> K;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[gcd_pkg::CW-1]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + ATAN;
			end
			neg_q <= neg_in;
		end
	end

endmodule

// ----- design/gcd_sqrt_cell.sv -----
// one digit step of a pipelined integer square root (two radicand bits per cell)
// depends on gcd_pkg
module gcd_sqrt_cell (
	input  logic                         clk,
	input  logic                         en,
	input  logic [gcd_pkg::SQ_NW-1:0]    n_in,
	input  logic [gcd_pkg::SQ_RW-1:0]    rem_in,
	input  logic [gcd_pkg::SQ_QW-1:0]    root_in,
	output logic [gcd_pkg::SQ_NW-1:0]    n_q,
	output logic [gcd_pkg::SQ_RW-1:0]    rem_q,
	output logic [gcd_pkg::SQ_QW-1:0]    root_q
);

	logic [gcd_pkg::SQ_RW-1:0] t;
	logic [gcd_pkg::SQ_RW-1:0] trial;
	logic                      ge;

	always_comb begin
		t     = {rem_in[gcd_pkg::SQ_RW-3:0], n_in[gcd_pkg::SQ_NW-1 -: 2]};
		trial = {3'b000, root_in, 2'b01};
		ge    = (t >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_q    <= {n_in[gcd_pkg::SQ_NW-3:0], 2'b00};
			rem_q  <= ge ? (t - trial) : t;
			root_q <= {root_in[gcd_pkg::SQ_QW-2:0], ge};
		end
	end

endmodule

// ----- design/gcd_vec_cell.sv -----
// one vectoring-mode cordic micro-rotation (arctangent)
// depends on gcd_pkg
module gcd_vec_cell #(
	parameter int K = 0
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [gcd_pkg::CW-1:0]  x_in,
	input  logic signed [gcd_pkg::CW-1:0]  y_in,
	input  logic signed [gcd_pkg::CW-1:0]  z_in,
	output logic signed [gcd_pkg::CW-1:0]  x_q,
	output logic signed [gcd_pkg::CW-1:0]  y_q,
	output logic signed [gcd_pkg::CW-1:0]  z_q
);

	localparam logic signed [gcd_pkg::CW-1:0] ATAN =
		$signed({2'b00, gcd_pkg::atan_val(K)});

	logic signed [gcd_pkg::CW-1:0] dx;
	logic signed [gcd_pkg::CW-1:0] dy;

	assign dx = y_in >>> K;
	assign dy = x_in >>> K;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[gcd_pkg::CW-1]) begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + ATAN;
			end else begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - ATAN;
			end
		end
	end

endmodule

// ----- design/great_circle_distance_top.sv -----
// great-circle distance top level: divider, cordic, square root and scaling pipeline
// depends on gcd_pkg, gcd_div_cell, gcd_rot_cell, gcd_sqrt_cell, gcd_vec_cell
//
// usage
//   input channel: in_valid / in_stall with lat_a, lon_a, lat_b, lon_b
//   (2^-ANGLE_FRAC_BITS degree, two's complement). a transaction completes
//   on a rising edge with in_valid high and in_stall low.
//   output channel: out_valid / out_stall with distance, the great-circle
//   distance in the unit of sphere_radius (1/65536 nm), saturating at all ones.
//   sphere_radius is written through cfg_wr_en / cfg_wr_data; the user
//   must do so only while idle, which goes unchecked by the block itself.
// throughput: one transaction per cycle while no result is held stalled
//   at the output; the pipe is a chain of cells: three reciprocal
//   divider cells, a rotation and a vectoring cordic chain of
//   CORDIC_STAGES cells each, 31 square root cells and six multiply/clamp stages
// stall and reset
//   the whole pipe freezes while a result is held stalled at the output, and
//   in_stall is raised in that cycle; payload held at the output does not change.
//   reset clears all stage valid bits and loads the earth radius.
module great_circle_distance_top #(
	parameter int ANGLE_FRAC_BITS = 22,
	parameter int CORDIC_STAGES   = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [29:0] lat_a,
	input  logic signed [30:0] lon_a,
	input  logic signed [29:0] lat_b,
	input  logic signed [30:0] lon_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        distance,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data
);

	localparam int SH  = 32 - ANGLE_FRAC_BITS;   // degree to binary angle shift
	localparam int NW  = gcd_pkg::DIV_W;         // dividend width
	localparam int DC  = gcd_pkg::DIV_CELLS;     // divider cells
	localparam int CS  = CORDIC_STAGES;
	localparam int CW  = gcd_pkg::CW;
	localparam int SQN = gcd_pkg::SQ_CELLS;
	localparam int LAT = DC + 2 * CS + SQN + 6;
	localparam int SQ_END = DC + CS + 3 + SQN - 1;   // valid bit of square root outputs

	// rounding of a q30 x q30 product
	function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + 64'sd536870912) >>> 30;
		return r[31:0];
	endfunction

	logic           en;
	logic [LAT-1:0] v_q;
	logic [31:0]    radius_q;

	// global advance: freeze only while a finished result is stalled
	assign en        = !(v_q[LAT-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = v_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= gcd_pkg::RADIUS_RESET;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	// angle magnitudes: lat_a, lat_b, dlat, dlon
	logic signed [31:0] dv   [4];
	logic        [31:0] ng32 [4];
	logic        [30:0] mag  [4];
	logic               neg_v[4];
	logic    [NW-1:0]   dn0  [4];

	// the power of two in 360 or 720 comes off the shift, leaving a division by 45
	always_comb begin
		dv[0] = {{2{lat_a[29]}}, lat_a};
		dv[1] = {{2{lat_b[29]}}, lat_b};
		dv[2] = dv[1] - dv[0];
		dv[3] = {lon_b[30], lon_b} - {lon_a[30], lon_a};
		for (int c = 0; c < 4; c++) begin
			ng32[c]  = -dv[c];
			neg_v[c] = dv[c][31];
			mag[c]   = neg_v[c] ? ng32[c][30:0] : dv[c][30:0];
			dn0[c]   = (NW'(mag[c]) << ((c < 2) ? (SH - gcd_pkg::FULL_SH)
					: (SH - gcd_pkg::HALF_SH)))
				+ NW'(gcd_pkg::DIV_BIAS);
		end
	end

	// divider chains
	logic [NW-1:0]              d_n  [4][DC+1];
	logic [gcd_pkg::REM_W-1:0]  d_r  [4][DC+1];
	logic [31:0]                d_q  [4][DC+1];
	logic                       d_ng [4][DC+1];

	// rotation cordic chains
	logic signed [CW-1:0] r_x  [4][CS+1];
	logic signed [CW-1:0] r_y  [4][CS+1];
	logic signed [CW-1:0] r_z  [4][CS+1];
	logic                 r_ng [4][CS+1];
	logic signed [31:0]   trig [4];   // cos lat_a, cos lat_b, sin dlat/2, sin dlon/2

	for (genvar c = 0; c < 4; c++) begin : g_ang
		assign d_n[c][0]  = dn0[c];
		assign d_r[c][0]  = '0;
		assign d_q[c][0]  = '0;
		assign d_ng[c][0] = neg_v[c];

		for (genvar i = 0; i < DC; i++) begin : g_div
			gcd_div_cell u_div (
				.clk    (clk),
				.en     (en),
				.n_in   (d_n[c][i]),
				.rem_in (d_r[c][i]),
				.q_in   (d_q[c][i]),
				.neg_in (d_ng[c][i]),
				.n_q    (d_n[c][i+1]),
				.rem_q  (d_r[c][i+1]),
				.q_q    (d_q[c][i+1]),
				.neg_q  (d_ng[c][i+1])
			);
		end

		// signed binary angle, folded into the right half plane
		logic [31:0]          ang;
		logic                 fold;
		logic [31:0]          ang_f;
		logic signed [CW-1:0] sel;
		logic signed [CW-1:0] sel_n;

		assign ang   = d_ng[c][DC] ? (32'd0 - d_q[c][DC]) : d_q[c][DC];
		assign fold  = ang[31] ^ ang[30];
		assign ang_f = {ang[31] ^ fold, ang[30:0]};

		assign r_x[c][0]  = $signed({2'b00, gcd_pkg::CORDIC_GAIN});
		assign r_y[c][0]  = '0;
		assign r_z[c][0]  = $signed({{(CW-32){ang_f[31]}}, ang_f});
		assign r_ng[c][0] = fold;

		for (genvar i = 0; i < CS; i++) begin : g_rot
			gcd_rot_cell #(.K(i % 32)) u_rot (
				.clk    (clk),
				.en     (en),
				.x_in   (r_x[c][i]),
				.y_in   (r_y[c][i]),
				.z_in   (r_z[c][i]),
				.neg_in (r_ng[c][i]),
				.x_q    (r_x[c][i+1]),
				.y_q    (r_y[c][i+1]),
				.z_q    (r_z[c][i+1]),
				.neg_q  (r_ng[c][i+1])
			);
		end

		// latitudes need the cosine, half differences the sine
		assign sel     = (c < 2) ? r_x[c][CS] : r_y[c][CS];
		assign sel_n   = r_ng[c][CS] ? -sel : sel;
		assign trig[c] = sel_n[31:0];
	end

	// haversine term
	logic signed [31:0] sl2_s1, c12_s1, so2_s1;
	logic signed [31:0] sl2_s2, t_s2;
	logic        [30:0] a_s3;
	logic signed [63:0] p_sl, p_cc, p_so, p_t;
	logic signed [32:0] a_sum;

	assign p_sl = 64'(trig[2]) * 64'(trig[2]);
	assign p_cc = 64'(trig[0]) * 64'(trig[1]);
	assign p_so = 64'(trig[3]) * 64'(trig[3]);
	assign p_t  = 64'(c12_s1) * 64'(so2_s1);
	assign a_sum = 33'(sl2_s2) + 33'(t_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			sl2_s1 <= rnd30(p_sl);
			c12_s1 <= rnd30(p_cc);
			so2_s1 <= rnd30(p_so);
			sl2_s2 <= sl2_s1;
			t_s2   <= rnd30(p_t);
			// clamp to [0, 1] in q30
			if (a_sum[32]) begin
				a_s3 <= '0;
			end else if (a_sum > 33'sd1073741824) begin
				a_s3 <= gcd_pkg::Q30_ONE;
			end else begin
				a_s3 <= a_sum[30:0];
			end
		end
	end

	// square roots of a and 1 - a
	logic [gcd_pkg::SQ_NW-1:0] s_n    [2][SQN+1];
	logic [gcd_pkg::SQ_RW-1:0] s_r    [2][SQN+1];
	logic [gcd_pkg::SQ_QW-1:0] s_root [2][SQN+1];
	logic [30:0]               b_val;

	assign b_val = gcd_pkg::Q30_ONE - a_s3;
	assign s_n[0][0] = {1'b0, a_s3, 30'd0};
	assign s_n[1][0] = {1'b0, b_val, 30'd0};

	for (genvar c = 0; c < 2; c++) begin : g_sq
		assign s_r[c][0]    = '0;
		assign s_root[c][0] = '0;
		for (genvar i = 0; i < SQN; i++) begin : g_cell
			gcd_sqrt_cell u_sqrt (
				.clk     (clk),
				.en      (en),
				.n_in    (s_n[c][i]),
				.rem_in  (s_r[c][i]),
				.root_in (s_root[c][i]),
				.n_q     (s_n[c][i+1]),
				.rem_q   (s_r[c][i+1]),
				.root_q  (s_root[c][i+1])
			);
		end
	end

	// arctangent of sqrt(a) / sqrt(1 - a)
	logic signed [CW-1:0] v_x [CS+1];
	logic signed [CW-1:0] v_y [CS+1];
	logic signed [CW-1:0] v_z [CS+1];

	assign v_x[0] = $signed({{(CW-gcd_pkg::SQ_QW){1'b0}}, s_root[1][SQN]});
	assign v_y[0] = $signed({{(CW-gcd_pkg::SQ_QW){1'b0}}, s_root[0][SQN]});
	assign v_z[0] = '0;

	for (genvar i = 0; i < CS; i++) begin : g_vec
		gcd_vec_cell #(.K(i % 32)) u_vec (
			.clk  (clk),
			.en   (en),
			.x_in (v_x[i]),
			.y_in (v_y[i]),
			.z_in (v_z[i]),
			.x_q  (v_x[i+1]),
			.y_q  (v_y[i+1]),
			.z_q  (v_z[i+1])
		);
	end

	// scale by pi and radius
	logic [30:0] zc;
	logic [63:0] zpi;
	logic [63:0] zpi_r;
	logic [34:0] zp_s4;
	logic [50:0] ph;
	logic [50:0] pl;
	logic [50:0] ph_s5;
	logic [34:0] pl_s5;
	logic [51:0] t_sum;
	logic [51:0] t_rnd;
	logic [31:0] distance_s6;

	always_comb begin
		if (v_z[CS][CW-1]) begin
			zc = '0;
		end else if (v_z[CS] > $signed({{(CW-31){1'b0}}, gcd_pkg::Q30_ONE})) begin
			zc = gcd_pkg::Q30_ONE;
		end else begin
			zc = v_z[CS][30:0];
		end
		zpi   = 64'(zc) * 64'(gcd_pkg::PI_Q31);
		zpi_r = (zpi + 64'd268435456) >> 29;
		ph    = 51'(zp_s4) * 51'(radius_q[31:16]);
		pl    = 51'(zp_s4) * 51'(radius_q[15:0]);
		t_sum = 52'(ph_s5) + 52'(pl_s5);
		t_rnd = (t_sum + 52'h8000) >> 16;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zp_s4 <= zpi_r[34:0];
			ph_s5 <= ph;
			pl_s5 <= pl[50:16];
			distance_s6 <= (t_rnd > 52'hFFFF_FFFF) ? 32'hFFFF_FFFF : t_rnd[31:0];
		end
	end

	assign distance = distance_s6;

`ifndef SYNTHESIS
	// a zero radius can only give a zero distance
	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (radius_q == 32'd0) && $stable(radius_q) |-> distance == 32'd0)
		else $error("nonzero distance with zero radius");

	// both square roots of a clamped q30 value stay within one
	a_sqrt_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[SQ_END] |-> (s_root[0][SQN] <= 31'h4000_0000)
			&& (s_root[1][SQN] <= 31'h4000_0000))
		else $error("square root out of range");

	// a frozen pipe keeps its occupancy
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q))
		else $error("stage valid bits moved while stalled");
`endif

endmodule

// ----- bench/great_circle_distance_checker.sv -----
// checker for the great-circle distance block: watches both channels and the radius write port
// predicts each distance with its own haversine/cordic model; depends on gcd_pkg for the reset radius
module great_circle_distance_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [29:0] lat_a,
	input  logic signed [30:0] lon_a,
	input  logic signed [29:0] lat_b,
	input  logic signed [30:0] lon_b,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [31:0]        distance,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	output int                 fail_count,
	output int                 pending
);

	localparam int     STAGES   = 24;
	localparam int     FRAC     = 22;
	localparam longint GAIN     = 64'd652032874;
	localparam longint PI_SCALE = 64'd6746518852;
	localparam longint ONE_Q30  = 64'd1 << 30;

	logic [31:0] radius;
	logic [31:0] distance_q[$];
	int          mismatches;

	function automatic longint step_angle(input int k);
		logic [31:0] v;
		case (k)
			0:  v = 32'h2000_0000;
			1:  v = 32'h12E4_051D;
			2:  v = 32'h09FB_385B;
			3:  v = 32'h0511_11D4;
			4:  v = 32'h028B_0D43;
			5:  v = 32'h0145_D7E1;
			6:  v = 32'h00A2_F61E;
			7:  v = 32'h0051_7C55;
			8:  v = 32'h0028_BE53;
			9:  v = 32'h0014_5F2E;
			10: v = 32'h000A_2F98;
			11: v = 32'h0005_17CC;
			12: v = 32'h0002_8BE6;
			13: v = 32'h0001_45F3;
			14: v = 32'h0000_A2F9;
			15: v = 32'h0000_517C;
			16: v = 32'h0000_28BE;
			17: v = 32'h0000_145F;
			18: v = 32'h0000_0A2F;
			19: v = 32'h0000_0517;
			20: v = 32'h0000_028B;
			21: v = 32'h0000_0145;
			22: v = 32'h0000_00A2;
			23: v = 32'h0000_0051;
			24: v = 32'h0000_0028;
			25: v = 32'h0000_0014;
			26: v = 32'h0000_000A;
			27: v = 32'h0000_0005;
			28: v = 32'h0000_0002;
			29: v = 32'h0000_0001;
			default: v = 32'h0;
		endcase
		return longint'({32'h0, v});
	endfunction

	function automatic logic [31:0] bin_angle(input longint deg, input longint div);
		longint m;
		longint q;
		m = (deg < 0) ? -deg : deg;
		q = ((m <<< (32 - FRAC)) + div / 2) / div;
		if (deg < 0)
			q = -q;
		return q[31:0];
	endfunction

	function automatic void sin_cos(input logic [31:0] ang, output longint s, output longint c);
		longint x, y, z, dx, dy;
		logic neg;
		logic [31:0] a;
		a = ang;
		neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
		if (neg)
			a = a + 32'h8000_0000;
		z = longint'($signed(a));
		x = GAIN;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - step_angle(i);
			end else begin
				x = x + dx; y = y - dy; z = z + step_angle(i);
			end
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endfunction

	function automatic longint vector_angle(input longint yin, input longint xin);
		longint x, y, z, dx, dy;
		x = xin;
		y = yin;
		z = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx; y = y - dy; z = z + step_angle(i);
			end else begin
				x = x - dx; y = y + dy; z = z - step_angle(i);
			end
		end
		if (z < 0)
			z = 0;
		if (z > ONE_Q30)
			z = ONE_Q30;
		return z;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n_in);
		logic [63:0] n, r, b;
		n = n_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint round_q30(input longint v);
		return (v + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic [31:0] haversine_distance(input logic [31:0] rad,
			input longint la, input longint oa, input longint lb, input longint ob);
		longint s1, c1, s2, c2, sl, cl, so, co, a, z;
		logic [63:0] ra, rb, zp, rh, rl, t;
		sin_cos(bin_angle(la, 360), s1, c1);
		sin_cos(bin_angle(lb, 360), s2, c2);
		sin_cos(bin_angle(lb - la, 720), sl, cl);
		sin_cos(bin_angle(ob - oa, 720), so, co);
		a = round_q30(sl * sl) + round_q30(round_q30(c1 * c2) * round_q30(so * so));
		if (a < 0)
			a = 0;
		if (a > ONE_Q30)
			a = ONE_Q30;
		ra = floor_sqrt(a << 30);
		rb = floor_sqrt((ONE_Q30 - a) << 30);
		z = vector_angle(longint'(ra), longint'(rb));
		zp = (z * PI_SCALE + (64'd1 << 28)) >> 29;
		rh = {48'h0, rad[31:16]};
		rl = {48'h0, rad[15:0]};
		t = zp * rh + ((zp * rl) >> 16);
		t = (t + 64'h8000) >> 16;
		if (t > 64'hFFFF_FFFF)
			t = 64'hFFFF_FFFF;
		return t[31:0];
	endfunction

	assign pending = distance_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius <= gcd_pkg::RADIUS_RESET;
			fail_count <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_wr_en)
				radius <= cfg_wr_data;
			if (in_valid && !in_stall)
				distance_q.push_back(haversine_distance(radius, longint'(lat_a),
					longint'(lon_a), longint'(lat_b), longint'(lon_b)));
			if (out_valid && !out_stall) begin
				if (distance_q.size() == 0) begin
					fail_count <= fail_count + 1;
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected distance transaction: %0d", distance);
				end else begin
					if (distance !== distance_q[0]) begin
						fail_count <= fail_count + 1;
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("distance mismatch: expected %0d actual %0d",
								distance_q[0], distance);
					end
					void'(distance_q.pop_front());
				end
			end
		end
	end

endmodule

// ----- bench/great_circle_distance_top_tb.sv -----
// stimulus and verdict for the great-circle distance block
// depends on gcd_pkg, great_circle_distance_top and great_circle_distance_checker
module great_circle_distance_top_tb;

	localparam int LAT_MAX   = 377487360;
	localparam int LON_MAX   = 754974720;
	localparam int DRAIN_CYC = 160;   // well over the depth of the pipe

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [29:0] lat_a;
	logic signed [30:0] lon_a;
	logic signed [29:0] lat_b;
	logic signed [30:0] lon_b;
	logic               out_valid;
	logic               out_stall;
	logic [31:0]        distance;
	logic               cfg_wr_en;
	logic [31:0]        cfg_wr_data;
	int                 fail_count;
	int                 pending;
	logic               quiet;    // when set, neither side idles

	great_circle_distance_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.out_valid(out_valid), .out_stall(out_stall), .distance(distance),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	great_circle_distance_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.out_valid(out_valid), .out_stall(out_stall), .distance(distance),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count), .pending(pending)
	);

	// 4 unit clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// one position pair per transaction; valid stays high across back-to-back items
	task automatic send_pair(input int la, input int oa, input int lb, input int ob);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		lat_a <= la[29:0];
		lon_a <= oa[30:0];
		lat_b <= lb[29:0];
		lon_b <= ob[30:0];
		in_valid <= 1'b1;
		// wait for the accepting edge
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// wait until every predicted distance has come back, then let the pipe settle
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	// radius is only written while the pipe is empty
	task automatic write_radius(input logic [31:0] value);
		drain_pipe();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int rand_span(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// mostly legal coordinates, with some raw full-width words for every bit
	task automatic send_random();
		if ($urandom_range(0, 4) == 0)
			send_pair($urandom(), $urandom(), $urandom(), $urandom());
		else if ($urandom_range(0, 5) == 0)
			// nearby points, the common tracking case
			begin : near
				int la, oa;
				la = rand_span(LAT_MAX);
				oa = rand_span(LON_MAX);
				send_pair(la, oa, la + rand_span(4096), oa + rand_span(4096));
			end
		else
			send_pair(rand_span(LAT_MAX), rand_span(LON_MAX),
				rand_span(LAT_MAX), rand_span(LON_MAX));
	endtask

	// receiver: per result a random stall, with quiet stretches
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin : recv
			int n;
			n = quiet ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	initial begin : stimulus
		logic [31:0] radii[5];
		radii[0] = 32'd1;
		radii[1] = 32'hFFFF_FFFF;
		radii[2] = 32'd0;
		radii[3] = $urandom();
		radii[4] = gcd_pkg::RADIUS_RESET;
		in_valid = 1'b0;
		lat_a = '0;
		lon_a = '0;
		lat_b = '0;
		lon_b = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		quiet = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: earth radius from reset
		send_pair(0, 0, 0, 0);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);              // pole to pole
		send_pair(0, -LON_MAX, 0, LON_MAX);              // same meridian from both sides
		send_pair(0, 0, 0, LON_MAX);                     // antipodes on the equator
		send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
		send_pair(-LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX);
		send_pair(-LAT_MAX, 0, LAT_MAX, LON_MAX);
		send_pair(1, 1, 0, 0);                           // one lsb apart
		send_pair(-1, -1, 0, 0);
		send_pair(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 3, -LON_MAX / 2);
		// latitudes past the poles can drive a below zero
		send_pair(32'h1FFF_FFFF, 0, 32'h1FFF_FFFF, LON_MAX);
		send_pair(-32'sh2000_0000, 0, 32'h1FFF_FFFF, LON_MAX);
		send_pair(32'h1FFF_FFFF, 0, -32'sh2000_0000, 0);
		// longitudes past 180 degrees wrap
		send_pair(0, 32'h3FFF_FFFF, 0, -32'sh4000_0000);
		send_pair(LAT_MAX / 4, -32'sh4000_0000, LAT_MAX / 5, 32'h3FFF_FFFF);
		// a past one near the antipode
		send_pair(LAT_MAX / 2, 0, -LAT_MAX / 2, LON_MAX);
		send_pair(1, 0, -1, LON_MAX);
		send_pair(-32'sh2000_0000, -32'sh4000_0000, 32'h1FFF_FFFF, 32'h3FFF_FFFF);

		// at least one pause until every result has drained
		drain_pipe();

		// random phases over several radii, each starts with extremes at that radius
		foreach (radii[p]) begin
			write_radius(radii[p]);
			send_pair(0, 0, 0, LON_MAX);
			send_pair(LAT_MAX, 0, -LAT_MAX, 0);
			for (int i = 0; i < 264; i++) begin
				// quiet stretches with no idling on either side
				if (i % 60 == 0)
					quiet = ($urandom_range(0, 2) == 0);
				send_random();
			end
			quiet = 1'b0;
		end

		drain_pipe();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- great_circle_distance_top.f -----
design/gcd_pkg.sv
design/gcd_div_cell.sv
design/gcd_rot_cell.sv
design/gcd_sqrt_cell.sv
design/gcd_vec_cell.sv
design/great_circle_distance_top.sv
bench/great_circle_distance_checker.sv
bench/great_circle_distance_top_tb.sv
